[rtl/cia_pkg.sv]
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and codes for the checked signed 32-bit ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int W = 32;

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_MOD = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_DIV_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]      action;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } in_beat_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]      status;
    } out_beat_t;

    // state handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic [2:0]  action;
        logic [31:0] a;
        logic [31:0] b;
        logic        neg_q;    // quotient sign
        logic        neg_r;    // remainder sign
        logic [31:0] rem;      // partial remainder (magnitude)
        logic [31:0] quo;      // dividend shift / quotient bits
        logic [31:0] dvs;      // divisor magnitude
        logic signed [32:0] sum;  // add/sub result, 33 bits
        logic signed [63:0] prod; // multiply result
    } cell_t;

endpackage

[rtl/cia_cell.sv]
// ----------------------------------------------------------------------------
// cia_cell
// One restoring-division step; carries the rest of the beat along.
// ----------------------------------------------------------------------------
module cia_cell
    import cia_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  advance,
    input  cell_t cell_in,
    output cell_t cell_out
);

    cell_t cell_reg;
    cell_t cell_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb begin
        cell_next = cell_in;
        trial = {cell_in.rem, cell_in.quo[31]};
        diff  = trial - {1'b0, cell_in.dvs};
        if (!diff[32]) begin
            cell_next.rem = diff[31:0];
            cell_next.quo = {cell_in.quo[30:0], 1'b1};
        end else begin
            cell_next.rem = trial[31:0];
            cell_next.quo = {cell_in.quo[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (advance) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

[rtl/checked_int32_alu.sv]
// ----------------------------------------------------------------------------
// checked_int32_alu
// Signed 32-bit add, subtract, multiply, divide and modulo with status.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat is accepted every cycle while the output is not
// stalled; each beat passes through one entry stage, 32 division cells of one
// quotient bit each, and one output stage. Pipeline depth is set by the
// division cell chain; the multiply runs in the entry stage and its 64-bit
// product rides the chain.
// Whole pipeline stalls while the output register holds an untaken beat.
module checked_int32_alu
    import cia_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam int NCELL = W;

    cell_t     chain [NCELL+1];
    cell_t     entry_next;
    out_beat_t out_reg, out_next;
    logic      out_valid_reg;
    logic      advance;
    logic      s_fire;
    logic [31:0] mag_a, mag_b;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        mag_a = s_data.operand_a[31] ? 32'(-s_data.operand_a) : s_data.operand_a;
        mag_b = s_data.operand_b[31] ? 32'(-s_data.operand_b) : s_data.operand_b;
        entry_next.valid  = s_fire;
        entry_next.action = s_data.action;
        entry_next.a      = s_data.operand_a;
        entry_next.b      = s_data.operand_b;
        entry_next.neg_q  = s_data.operand_a[31] ^ s_data.operand_b[31];
        entry_next.neg_r  = s_data.operand_a[31];
        entry_next.rem    = '0;
        entry_next.quo    = mag_a;
        entry_next.dvs    = mag_b;
        if (s_data.action == ACT_SUB) begin
            entry_next.sum = 33'(s_data.operand_a) - 33'(s_data.operand_b);
        end else begin
            entry_next.sum = 33'(s_data.operand_a) + 33'(s_data.operand_b);
        end
        entry_next.prod = 64'(s_data.operand_a) * 64'(s_data.operand_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain[0].valid <= 1'b0;
        end else if (advance) begin
            chain[0] <= entry_next;
        end
    end

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        cia_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    cell_t last;
    logic [31:0] qv, rv;
    assign last = chain[NCELL];

    always_comb begin
        qv = last.neg_q ? 32'(-last.quo) : last.quo;
        rv = last.neg_r ? 32'(-last.rem) : last.rem;
        out_next.value  = '0;
        out_next.status = ST_OK;
        case (last.action)
            ACT_ADD, ACT_SUB: begin
                if (last.sum[32] != last.sum[31]) begin
                    out_next.status = ST_OVERFLOW;
                end else begin
                    out_next.value = last.sum[31:0];
                end
            end
            ACT_MUL: begin
                if (last.prod[63:31] != {33{last.prod[31]}}) begin
                    out_next.status = ST_OVERFLOW;
                end else begin
                    out_next.value = last.prod[31:0];
                end
            end
            ACT_DIV, ACT_MOD: begin
                if (last.b == '0) begin
                    out_next.status = ST_DIV_ZERO;
                end else if (last.a == 32'h8000_0000 && last.b == 32'hFFFF_FFFF) begin
                    out_next.status = ST_OVERFLOW;
                end else if (last.action == ACT_DIV) begin
                    out_next.value = qv;
                end else begin
                    out_next.value = rv;
                end
            end
            default: begin
                out_next.value = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= last.valid;
            out_reg       <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.value == '0)
        else $error("nonzero value on error status");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output beat changed while stalled");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken during output stall");

endmodule
